>>> design/loor_pkg.sv
// loor_pkg: shared types, constants and helper functions for the long-object
// overlap ratio unit. No dependencies.
package loor_pkg;

    localparam int COLS_DEF  = 16;
    localparam int ROWS_DEF  = 16;
    localparam int HW        = 48;
    localparam int QW        = 16;
    localparam int DIV_STG   = QW;
    localparam int PRE_STG   = 5;
    localparam int NSTG      = PRE_STG + DIV_STG + 3;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic [2:0] REG_X_LO  = 3'd0;
    localparam logic [2:0] REG_X_HI  = 3'd1;
    localparam logic [2:0] REG_Y_LO  = 3'd2;
    localparam logic [2:0] REG_Y_HI  = 3'd3;
    localparam logic [2:0] REG_Z_LO  = 3'd4;
    localparam logic [2:0] REG_Z_HI  = 3'd5;
    localparam logic [2:0] REG_PITCH = 3'd6;

    typedef enum logic [1:0] {
        CLS_ZERO = 2'd0,
        CLS_ONE  = 2'd1,
        CLS_PART = 2'd2
    } t_cls;

    typedef struct packed {
        t_cls                  cls;
        logic                  hi_in;
        logic signed [HW-1:0]  hh;
        logic signed [HW-1:0]  hl;
        logic signed [HW-1:0]  c;
    } t_side;

    typedef struct packed {
        t_cls                  cls;
        logic signed [HW-1:0]  num;
        logic signed [HW-1:0]  den;
    } t_frac;

    typedef struct packed {
        logic [HW:0]    rem;
        logic [HW-1:0]  den;
        logic [QW-1:0]  quo;
        logic           div;
        logic [16:0]    fix;
    } t_div;

    function automatic t_side side_cmp(input logic signed [HW-1:0] hh,
                                       input logic signed [HW-1:0] hl,
                                       input logic signed [HW-1:0] lo,
                                       input logic signed [HW-1:0] hi);
        t_side s;
        logic  hhi;
        logic  hli;
        logic signed [HW-1:0] c;
        hhi = (hh >= lo) && (hh <= hi);
        hli = (hl >= lo) && (hl <= hi);
        if (hhi) begin
            c = (hl < lo) ? lo : hl;
        end else begin
            c = (hh < lo) ? lo : hh;
        end
        if (c > hi) begin
            c = hi;
        end
        if (((hh < lo) && (hl < lo)) || ((hh > hi) && (hl > hi))) begin
            s.cls = CLS_ZERO;
        end else if (hhi && hli) begin
            s.cls = CLS_ONE;
        end else begin
            s.cls = CLS_PART;
        end
        s.hi_in = hhi;
        s.hh    = hh;
        s.hl    = hl;
        s.c     = c;
        return s;
    endfunction

    function automatic t_frac side_sub(input t_side s);
        t_frac f;
        f.cls = s.cls;
        f.num = s.hi_in ? (s.hh - s.c) : (s.c - s.hl);
        f.den = s.hh - s.hl;
        return f;
    endfunction

    function automatic t_div frac_prep(input t_frac f);
        t_div d;
        logic signed [HW-1:0] n;
        logic signed [HW-1:0] dn;
        n  = f.den[HW-1] ? -f.num : f.num;
        dn = f.den[HW-1] ? -f.den : f.den;
        d.rem = {1'b0, n};
        d.den = dn;
        d.quo = '0;
        d.div = 1'b0;
        d.fix = '0;
        case (f.cls)
            CLS_ONE: d.fix = ONE_Q16;
            CLS_PART: begin
                if (f.den == '0 || n <= 0) begin
                    d.fix = '0;
                end else if (n >= dn) begin
                    d.fix = ONE_Q16;
                end else begin
                    d.div = 1'b1;
                end
            end
            default: d.fix = '0;
        endcase
        return d;
    endfunction

    function automatic t_div div_step(input t_div a);
        t_div       d;
        logic [HW:0] r2;
        d  = a;
        r2 = {a.rem[HW-1:0], 1'b0};
        if (r2 >= {1'b0, a.den}) begin
            d.rem = r2 - {1'b0, a.den};
            d.quo = {a.quo[QW-2:0], 1'b1};
        end else begin
            d.rem = r2;
            d.quo = {a.quo[QW-2:0], 1'b0};
        end
        return d;
    endfunction

    function automatic logic [16:0] div_ratio(input t_div a);
        return a.div ? {1'b0, a.quo} : a.fix;
    endfunction

endpackage

>>> design/long_object_overlap_ratio_unit.sv
// Long-object overlap ratio unit: throughput one beat per cycle unless an output beat
// held by i_out_ready stalls the pipe; the 16-stage restoring divider sets the depth.
// Synchronous active-low reset clears the stage valids and loads register defaults
// (bounds 0, pixel pitch 1.0). Depends on loor_pkg.
module long_object_overlap_ratio_unit #(
    parameter int COLS_PER_LENSLET = loor_pkg::COLS_DEF,
    parameter int ROWS_PER_LENSLET = loor_pkg::ROWS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [19:0] i_tan_x_angle,
    input  logic signed [19:0] i_tan_y_angle,
    input  logic [5:0]         i_pos_s,
    input  logic [5:0]         i_pos_t,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [16:0]        o_weight
);

    localparam logic signed [7:0] CENTER_X = 8'(COLS_PER_LENSLET - 1);
    localparam logic signed [7:0] CENTER_Y = 8'(ROWS_PER_LENSLET - 1);
    localparam int NS = loor_pkg::NSTG;
    localparam int PS = loor_pkg::PRE_STG;
    localparam int DS = loor_pkg::DIV_STG;

    logic signed [23:0] r_x_lo, r_x_hi, r_y_lo, r_y_hi, r_z_lo, r_z_hi;
    logic [15:0]        r_pitch;
    logic [NS-1:0]      r_vld;
    logic               en;

    logic signed [7:0]  pos_x, pos_y;
    logic signed [24:0] r_offx, r_offy;
    logic signed [43:0] r_pxh, r_pxl, r_pyh, r_pyl;
    logic signed [25:0] r_bxl, r_bxh, r_byl, r_byh;
    logic signed [43:0] r2_pxh, r2_pxl, r2_pyh, r2_pyl;
    loor_pkg::t_side    r_sx, r_sy;
    loor_pkg::t_frac    r_fx, r_fy;
    loor_pkg::t_div     r_dx [0:DS];
    loor_pkg::t_div     r_dy [0:DS];
    logic [16:0]        r_m, r_m2, n_m;
    logic [31:0]        r_sq;
    logic [47:0]        cube;
    logic [16:0]        r_w;

    assign en          = !r_vld[NS-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[NS-1];
    assign o_weight    = r_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_lo  <= '0;
            r_x_hi  <= '0;
            r_y_lo  <= '0;
            r_y_hi  <= '0;
            r_z_lo  <= '0;
            r_z_hi  <= '0;
            r_pitch <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                loor_pkg::REG_X_LO:  r_x_lo  <= i_cfg_data;
                loor_pkg::REG_X_HI:  r_x_hi  <= i_cfg_data;
                loor_pkg::REG_Y_LO:  r_y_lo  <= i_cfg_data;
                loor_pkg::REG_Y_HI:  r_y_hi  <= i_cfg_data;
                loor_pkg::REG_Z_LO:  r_z_lo  <= i_cfg_data;
                loor_pkg::REG_Z_HI:  r_z_hi  <= i_cfg_data;
                loor_pkg::REG_PITCH: r_pitch <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-2:0], i_in_valid};
        end
    end

    assign pos_x = signed'({1'b0, i_pos_s, 1'b0}) - CENTER_X;
    assign pos_y = signed'({1'b0, i_pos_t, 1'b0}) - CENTER_Y;

    assign n_m = (loor_pkg::div_ratio(r_dx[DS]) < loor_pkg::div_ratio(r_dy[DS]))
        ? loor_pkg::div_ratio(r_dx[DS]) : loor_pkg::div_ratio(r_dy[DS]);

    assign cube = r_sq * r_m2[15:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            // heights and lenslet offsets
            r_offx <= pos_x * signed'({1'b0, r_pitch});
            r_offy <= pos_y * signed'({1'b0, r_pitch});
            r_pxh  <= r_z_hi * i_tan_x_angle;
            r_pxl  <= r_z_lo * i_tan_x_angle;
            r_pyh  <= r_z_hi * i_tan_y_angle;
            r_pyl  <= r_z_lo * i_tan_y_angle;
            // bounds in Q.9
            r_bxl  <= {r_x_lo[23], r_x_lo, 1'b0} - {r_offx[24], r_offx};
            r_bxh  <= {r_x_hi[23], r_x_hi, 1'b0} - {r_offx[24], r_offx};
            r_byl  <= {r_y_lo[23], r_y_lo, 1'b0} - {r_offy[24], r_offy};
            r_byh  <= {r_y_hi[23], r_y_hi, 1'b0} - {r_offy[24], r_offy};
            r2_pxh <= r_pxh;
            r2_pxl <= r_pxl;
            r2_pyh <= r_pyh;
            r2_pyl <= r_pyl;
            // classify in Q.25
            r_sx <= loor_pkg::side_cmp({{3{r2_pxh[43]}}, r2_pxh, 1'b0},
                                       {{3{r2_pxl[43]}}, r2_pxl, 1'b0},
                                       {{6{r_bxl[25]}}, r_bxl, 16'h0000},
                                       {{6{r_bxh[25]}}, r_bxh, 16'h0000});
            r_sy <= loor_pkg::side_cmp({{3{r2_pyh[43]}}, r2_pyh, 1'b0},
                                       {{3{r2_pyl[43]}}, r2_pyl, 1'b0},
                                       {{6{r_byl[25]}}, r_byl, 16'h0000},
                                       {{6{r_byh[25]}}, r_byh, 16'h0000});
            r_fx <= loor_pkg::side_sub(r_sx);
            r_fy <= loor_pkg::side_sub(r_sy);
            r_dx[0] <= loor_pkg::frac_prep(r_fx);
            r_dy[0] <= loor_pkg::frac_prep(r_fy);
            for (int k = 1; k <= DS; k++) begin
                r_dx[k] <= loor_pkg::div_step(r_dx[k-1]);
                r_dy[k] <= loor_pkg::div_step(r_dy[k-1]);
            end
            // min, square, cube
            r_m  <= n_m;
            r_sq <= r_m[15:0] * r_m[15:0];
            r_m2 <= r_m;
            r_w  <= r_m2[16] ? loor_pkg::ONE_Q16 : {1'b0, cube[47:32]};
        end
    end

`ifndef NO_ASSERTIONS
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_weight <= loor_pkg::ONE_Q16))
        else $error("weight above one");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[PS-1] && r_dx[0].div) |-> (r_dx[0].rem < {1'b0, r_dx[0].den}))
        else $error("divider remainder not below divisor");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");
`endif

endmodule

>>> bench/long_object_overlap_ratio_unit_tb.sv
// Testbench for long_object_overlap_ratio_unit: drives pixel requests under random
// idling and backpressure, predicts each weight in 64-bit integer maths and checks
// every output beat in order. Depends on loor_pkg and the unit itself.
module long_object_overlap_ratio_unit_tb;

    localparam int           COLS      = 16;
    localparam int           ROWS      = 16;
    localparam int           LATENCY   = 24;
    localparam int           LIMIT     = 600000;
    localparam logic [2:0]   REG_SPARE = 3'd7;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [23:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [19:0] i_tan_x_angle = '0;
    logic signed [19:0] i_tan_y_angle = '0;
    logic [5:0]         i_pos_s = '0;
    logic [5:0]         i_pos_t = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [16:0]        o_weight;

    long_object_overlap_ratio_unit #(
        .COLS_PER_LENSLET(COLS),
        .ROWS_PER_LENSLET(ROWS)
    ) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_tan_x_angle(i_tan_x_angle), .i_tan_y_angle(i_tan_y_angle),
        .i_pos_s(i_pos_s), .i_pos_t(i_pos_t),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_weight(o_weight)
    );

    logic [23:0]  bound_q [0:5];
    logic [15:0]  pitch_q;
    logic [16:0]  weight_q [$];
    int           fails = 0;
    int           cycles = 0;
    bit           idle_en = 1'b1;
    int           hold_req = 0;
    int           hold_cnt = 0;
    int           ready_gap = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_ready <= 1'b0;
        end else if (ready_gap > 0) begin
            ready_gap--;
            i_out_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            ready_gap = $urandom_range(1, 17) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (weight_q.size() == 0) begin
                $error("weight: unexpected beat, actual %0d", o_weight);
                fails++;
            end else begin
                if (o_weight !== weight_q[0]) begin
                    $error("weight: expected %0d, actual %0d", weight_q[0], o_weight);
                    fails++;
                end
                void'(weight_q.pop_front());
            end
        end
    end

    function automatic longint clip_frac(longint num, longint den);
        if (den == 0) return 0;
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        if (num <= 0) return 0;
        if (num >= den) return 65536;
        return (num * 65536) / den;
    endfunction

    function automatic longint axis_cover(longint tn, longint lo, longint hi,
                                          longint zlo, longint zhi);
        longint hh, hl, c;
        bit     hh_in, hl_in;
        hh = zhi * tn * 2;
        hl = zlo * tn * 2;
        hh_in = (hh >= lo) && (hh <= hi);
        hl_in = (hl >= lo) && (hl <= hi);
        if ((hh < lo && hl < lo) || (hh > hi && hl > hi)) return 0;
        if (hh_in && hl_in) return 65536;
        if (hh_in) begin
            c = (hl < lo) ? lo : hl;
            if (c > hi) c = hi;
            return clip_frac(hh - c, hh - hl);
        end
        c = (hh < lo) ? lo : hh;
        if (c > hi) c = hi;
        return clip_frac(c - hl, hh - hl);
    endfunction

    function automatic logic [16:0] predict_weight(logic signed [19:0] tx,
                                                   logic signed [19:0] ty,
                                                   logic [5:0] s, logic [5:0] t);
        longint pitch, offx, offy, rx, ry, m, zlo, zhi;
        pitch = longint'(pitch_q);
        zlo = longint'($signed(bound_q[loor_pkg::REG_Z_LO]));
        zhi = longint'($signed(bound_q[loor_pkg::REG_Z_HI]));
        offx = (2 * longint'(s) - (COLS - 1)) * pitch;
        offy = (2 * longint'(t) - (ROWS - 1)) * pitch;
        rx = axis_cover(longint'(tx),
                        (2 * longint'($signed(bound_q[loor_pkg::REG_X_LO])) - offx) * 65536,
                        (2 * longint'($signed(bound_q[loor_pkg::REG_X_HI])) - offx) * 65536,
                        zlo, zhi);
        ry = axis_cover(longint'(ty),
                        (2 * longint'($signed(bound_q[loor_pkg::REG_Y_LO])) - offy) * 65536,
                        (2 * longint'($signed(bound_q[loor_pkg::REG_Y_HI])) - offy) * 65536,
                        zlo, zhi);
        m = (rx < ry) ? rx : ry;
        return 17'((m * m * m) >>> 32);
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        if (idx == loor_pkg::REG_PITCH) pitch_q = val[15:0];
        else if (idx != REG_SPARE) bound_q[idx] = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(logic signed [19:0] tx, logic signed [19:0] ty,
                              logic [5:0] s, logic [5:0] t);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_tan_x_angle <= tx;
        i_tan_y_angle <= ty;
        i_pos_s <= s;
        i_pos_t <= t;
        do @(posedge i_clk); while (!o_in_ready);
        weight_q.push_back(predict_weight(tx, ty, s, t));
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (weight_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 6) @(posedge i_clk);
    endtask

    function automatic logic [19:0] rand_tan;
        case ($urandom_range(0, 3))
            0: return 20'($urandom);
            1: return 20'($signed($urandom_range(0, 2047)) - 1024);
            default: return 20'($signed($urandom_range(0, 262143)) - 131072);
        endcase
    endfunction

    task automatic random_pixels(int n);
        repeat (n) send_pixel(rand_tan(), rand_tan(),
                              6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
    endtask

    task automatic random_setup;
        int zl, zh, xl, yl;
        zl = $urandom_range(0, 32767) - 16384;
        zh = zl + $urandom_range(0, 32767) - ($urandom_range(0, 7) == 0 ? 40000 : 0);
        xl = $urandom_range(0, 131071) - 65536;
        yl = $urandom_range(0, 131071) - 65536;
        write_reg(loor_pkg::REG_Z_LO, 24'(zl));
        write_reg(loor_pkg::REG_Z_HI, 24'(zh));
        write_reg(loor_pkg::REG_X_LO, 24'(xl));
        write_reg(loor_pkg::REG_X_HI, 24'(xl + $urandom_range(0, 131071) - 8192));
        write_reg(loor_pkg::REG_Y_LO, 24'(yl));
        write_reg(loor_pkg::REG_Y_HI, 24'(yl + $urandom_range(0, 131071) - 8192));
        write_reg(loor_pkg::REG_PITCH, 24'($urandom_range(0, 2047)));
    endtask

    task automatic test_reset_defaults;
        send_pixel(20'sd0, 20'sd0, 6'd0, 6'd0);
        send_pixel(20'sd65536, -20'sd65536, 6'd63, 6'd63);
        drain();
    endtask

    task automatic test_directed;
        write_reg(loor_pkg::REG_Z_LO, 24'(-2560));
        write_reg(loor_pkg::REG_Z_HI, 24'(5120));
        write_reg(loor_pkg::REG_X_LO, 24'(-4096));
        write_reg(loor_pkg::REG_X_HI, 24'(6000));
        write_reg(loor_pkg::REG_Y_LO, 24'(-3000));
        write_reg(loor_pkg::REG_Y_HI, 24'(3000));
        write_reg(loor_pkg::REG_PITCH, 24'd256);
        write_reg(REG_SPARE, 24'hFFFFFF);
        send_pixel(20'sd0, 20'sd0, 6'd7, 6'd8);
        send_pixel(20'sd65536, 20'sd65536, 6'd7, 6'd8);
        send_pixel(20'sd131072, -20'sd98304, 6'd0, 6'd15);
        send_pixel(20'sh7FFFF, 20'sh80000, 6'd0, 6'd0);
        send_pixel(20'sh80000, 20'sh7FFFF, 6'd63, 6'd63);
        send_pixel(20'sd1, -20'sd1, 6'd31, 6'd32);
        send_pixel(20'sd40000, 20'sd30000, 6'd63, 6'd0);
        send_pixel(-20'sd40000, -20'sd50000, 6'd16, 6'd16);
        drain();
        write_reg(loor_pkg::REG_PITCH, 24'd0);
        send_pixel(20'sd50000, 20'sd20000, 6'd63, 6'd0);
        send_pixel(-20'sd90000, 20'sd70000, 6'd0, 6'd63);
        drain();
        // inverted extents and depth order
        write_reg(loor_pkg::REG_X_LO, 24'(6000));
        write_reg(loor_pkg::REG_X_HI, 24'(-4096));
        write_reg(loor_pkg::REG_Z_LO, 24'(5120));
        write_reg(loor_pkg::REG_Z_HI, 24'(-2560));
        send_pixel(20'sd65536, 20'sd65536, 6'd7, 6'd8);
        send_pixel(-20'sd30000, 20'sd10000, 6'd3, 6'd9);
        drain();
        write_reg(loor_pkg::REG_X_LO, 24'h800000);
        write_reg(loor_pkg::REG_X_HI, 24'h7FFFFF);
        write_reg(loor_pkg::REG_Y_LO, 24'h800000);
        write_reg(loor_pkg::REG_Y_HI, 24'h7FFFFF);
        write_reg(loor_pkg::REG_Z_LO, 24'h800000);
        write_reg(loor_pkg::REG_Z_HI, 24'h7FFFFF);
        write_reg(loor_pkg::REG_PITCH, 24'hFFFF);
        send_pixel(20'sh7FFFF, 20'sh80000, 6'd63, 6'd0);
        send_pixel(20'sh80000, 20'sh7FFFF, 6'd0, 6'd63);
        send_pixel(20'sd16, -20'sd16, 6'd63, 6'd63);
        drain();
    endtask

    task automatic test_random_phases(int phases, int per_phase);
        repeat (phases) begin
            random_setup();
            random_pixels(per_phase);
            drain();
        end
    endtask

    task automatic test_backpressure;
        random_setup();
        hold_req = 300;
        random_pixels(80);
        drain();
    endtask

    initial begin
        foreach (bound_q[k]) bound_q[k] = '0;
        pitch_q = 16'd256;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_directed();
        test_random_phases(8, 100);
        idle_en = 1'b0;
        test_random_phases(2, 100);
        idle_en = 1'b1;
        test_backpressure();
        test_random_phases(4, 100);
        idle_en = 1'b0;
        test_random_phases(3, 100);
        if (fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

>>> sim.f
design/loor_pkg.sv
design/long_object_overlap_ratio_unit.sv
bench/long_object_overlap_ratio_unit_tb.sv
